// ===== hdl/frame_protocol_classifier_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the frame classifier checker.
// ---------------------------------------------------------------------------
`ifndef FRAME_PROTOCOL_CLASSIFIER_MACROS_SVH
`define FRAME_PROTOCOL_CLASSIFIER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the clock edge after the antecedent.
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fpc_pkg.sv =====
// ---------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the frame protocol classifier.
// ---------------------------------------------------------------------------
package fpc_pkg;

    // Result class codes.
    typedef enum logic [3:0] {
        CLS_NONE       = 4'd0,
        CLS_HTTP_REQ   = 4'd1,
        CLS_HTTP_RESP  = 4'd2,
        CLS_HTTP_BAD   = 4'd3,
        CLS_DNS_QUERY  = 4'd4,
        CLS_DNS_RESP   = 4'd5,
        CLS_TLS_HSHAKE = 4'd6,
        CLS_TLS_DATA   = 4'd7,
        CLS_TLS_OTHER  = 4'd8
    } t_class;

    // Configuration register indexes.
    localparam logic [2:0] REG_HTTP_PORT  = 3'd0;
    localparam logic [2:0] REG_DNS_PORT   = 3'd1;
    localparam logic [2:0] REG_TLS_PORT   = 3'd2;
    localparam logic [2:0] REG_DNS_LIMIT  = 3'd3;
    localparam logic [2:0] REG_TLS_MINVER = 3'd4;
    localparam logic [2:0] REG_HTTP_WIN   = 3'd5;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Request matcher phases, one-hot.
    typedef enum logic [4:0] {
        HM_METHOD = 5'b00001,
        HM_FIRST  = 5'b00010,
        HM_SCAN   = 5'b00100,
        HM_MATCH  = 5'b01000,
        HM_FAIL   = 5'b10000
    } t_hm_state;

    // Configuration registers as one bundle.
    typedef struct packed {
        logic [15:0] http_port;
        logic [15:0] dns_port;
        logic [15:0] tls_port;
        logic [15:0] dns_limit;
        logic [15:0] tls_minver;
        logic [15:0] http_window;
    } t_cfg;

    // Summary of the HTTP matchers at frame end.
    typedef struct packed {
        logic req;
        logic resp;
        logic any;
    } t_http_status;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // "HTTP/d.d ddd": check of byte b at position pos.
    function automatic logic resp_ok(input logic [3:0] pos, input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (pos)
            4'd0:  r = (b == 8'h48);
            4'd1:  r = (b == 8'h54);
            4'd2:  r = (b == 8'h54);
            4'd3:  r = (b == 8'h50);
            4'd4:  r = (b == 8'h2f);
            4'd5:  r = is_digit(b);
            4'd6:  r = (b == 8'h2e);
            4'd7:  r = is_digit(b);
            4'd8:  r = (b == 8'h20);
            4'd9:  r = is_digit(b);
            4'd10: r = is_digit(b);
            4'd11: r = is_digit(b);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Length of each request method name.
    function automatic logic [2:0] method_len(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            3'd0: r = 3'd3;
            3'd1: r = 3'd4;
            3'd2: r = 3'd4;
            3'd3: r = 3'd3;
            3'd4: r = 3'd6;
            3'd5: r = 3'd7;
            3'd6: r = 3'd5;
            3'd7: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Character i of method m.
    function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] i);
        logic [55:0] s;
        case (m)
            3'd0: s = {"GET", 32'd0};
            3'd1: s = {"POST", 24'd0};
            3'd2: s = {"HEAD", 24'd0};
            3'd3: s = {"PUT", 32'd0};
            3'd4: s = {"DELETE", 8'd0};
            3'd5: s = "OPTIONS";
            3'd6: s = {"TRACE", 16'd0};
            3'd7: s = "CONNECT";
            default: s = '0;
        endcase
        return s[8'(55 - 8 * 32'(i)) -: 8];
    endfunction

endpackage

// ===== hdl/fpc_http_match.sv =====
// ---------------------------------------------------------------------------
// fpc_http_match
// Streaming HTTP first-line matchers: request line, status line and any
// occurrence of "HTTP/".
// ---------------------------------------------------------------------------
module fpc_http_match (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_en,
    input  logic [15:0]           i_pos,
    input  logic [7:0]            i_byte,
    output fpc_pkg::t_http_status o_status
);
    import fpc_pkg::*;

    t_hm_state r_state, n_state;
    logic [7:0] r_mask, n_mask;
    logic [3:0] r_req, n_req;
    logic [3:0] r_resp, n_resp;
    logic [2:0] r_any, n_any;
    logic       nl;
    logic [7:0] lit_any;

    assign nl = (i_byte == 8'h0d) || (i_byte == 8'h0a);

    always_comb begin
        case (r_any)
            3'd0: lit_any = 8'h48;
            3'd1: lit_any = 8'h54;
            3'd2: lit_any = 8'h54;
            3'd3: lit_any = 8'h50;
            3'd4: lit_any = 8'h2f;
            default: lit_any = 8'h00;
        endcase
    end

    // Next state of all matchers for one payload byte.
    always_comb begin
        logic hit;
        logic done;
        hit = 1'b0;
        done = 1'b0;
        n_state = r_state;
        n_mask = r_mask;
        n_req = r_req;
        n_resp = r_resp;
        n_any = r_any;
        if (i_en) begin
            if (r_any < 3'd5) begin
                if (i_byte == lit_any) n_any = r_any + 3'd1;
                else n_any = (i_byte == 8'h48) ? 3'd1 : 3'd0;
            end
            if (i_pos < 16'd12 && {12'd0, r_resp} == i_pos && resp_ok(i_pos[3:0], i_byte))
                n_resp = r_resp + 4'd1;
            case (r_state)
                HM_METHOD: begin
                    for (int m = 0; m < 8; m++) begin
                        if (r_mask[m] && !done) begin
                            if (i_pos < {13'd0, method_len(3'(m))}) begin
                                if (i_byte != method_char(3'(m), i_pos[2:0]))
                                    n_mask[m] = 1'b0;
                            end else if (i_pos == {13'd0, method_len(3'(m))}
                                         && i_byte == 8'h20) begin
                                hit = 1'b1;
                                done = 1'b1;
                            end else begin
                                n_mask[m] = 1'b0;
                            end
                        end
                    end
                    if (hit) n_state = HM_FIRST;
                    else if (n_mask == 8'd0) n_state = HM_FAIL;
                end
                HM_FIRST: begin
                    n_state = nl ? HM_FAIL : HM_SCAN;
                    n_req = 4'd0;
                end
                HM_SCAN: begin
                    if (nl) begin
                        n_state = HM_FAIL;
                    end else begin
                        if (r_req == 4'd0 ? (i_byte == 8'h20) : resp_ok(r_req - 4'd1, i_byte))
                            n_req = r_req + 4'd1;
                        else
                            n_req = (i_byte == 8'h20) ? 4'd1 : 4'd0;
                        if (n_req == 4'd9) n_state = HM_MATCH;
                    end
                end
                default: ;
            endcase
        end
    end

    // Matcher registers, cleared between frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= HM_METHOD;
            r_mask  <= 8'hff;
            r_req   <= 4'd0;
            r_resp  <= 4'd0;
            r_any   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_req   <= n_req;
            r_resp  <= n_resp;
            r_any   <= n_any;
        end
    end

    // Status as seen after the current byte.
    assign o_status.req  = (n_state == HM_MATCH);
    assign o_status.resp = (n_resp == 4'd12);
    assign o_status.any  = (n_any == 3'd5);

endmodule

// ===== hdl/frame_protocol_classifier.sv =====
// ---------------------------------------------------------------------------
// frame_protocol_classifier
// Byte-serial Ethernet/IPv4/TCP/UDP classifier for HTTP, DNS and TLS.
// ---------------------------------------------------------------------------
// The block takes one frame byte per cycle and never stalls the input while
// the result register is free or being emptied: each accepted byte updates
// the header field capture and the HTTP matchers, and the frame's result is
// loaded into the output register on the byte marked as the last. Throughput
// is one byte per clock while o_stall is low; a result appears in the cycle
// after its last byte is accepted. Counters are COUNTER_BITS wide and wrap.
module frame_protocol_classifier #(
    parameter int HEAD_BYTES   = 12,
    parameter int COUNTER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_frame_class,
    output logic        o_anomaly_seen,
    output logic [31:0] o_class_total,
    output logic [31:0] o_anomaly_total,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import fpc_pkg::*;

    localparam int HIDX = $clog2(HEAD_BYTES);
    localparam int CW   = COUNTER_BITS;

    t_cfg r_cfg;
    logic [15:0] r_off;
    logic [15:0] r_ether;
    logic [5:0]  r_iphl;
    logic [7:0]  r_proto;
    logic [5:0]  r_thl;
    logic [15:0] r_sport, r_dport;
    logic [7:0]  r_head [HEAD_BYTES];
    logic [CW-1:0] r_cnt [7];
    logic        r_valid;
    logic [3:0]  r_class;
    logic        r_anom;
    logic [31:0] r_ctot, r_atot;

    logic accept, clear, take, pl_en, http_en;
    logic [15:0] n_ether, tstart, rel, ps, ppos;
    logic [5:0]  n_iphl, n_thl;
    logic [7:0]  n_proto;
    logic [15:0] n_sport, n_dport;
    logic ipv4_ok;
    t_http_status hs;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign clear   = accept && i_frame_end;
    assign take    = accept && (r_off != 16'hffff);

    // Header field capture, including the current byte.
    always_comb begin
        n_ether = r_ether;
        n_iphl  = r_iphl;
        n_proto = r_proto;
        if (take && r_off == 16'd12) n_ether = {i_frame_byte, 8'd0};
        if (take && r_off == 16'd13) n_ether = {r_ether[15:8], i_frame_byte};
        if (take && r_off == 16'd14) n_iphl = {i_frame_byte[3:0], 2'b00};
        if (take && r_off == 16'd23) n_proto = i_frame_byte;
    end

    assign ipv4_ok = (n_ether == ETHERTYPE_IPV4) && (n_iphl >= 6'd20) && (r_off >= 16'd14);
    assign tstart  = 16'd14 + {10'd0, n_iphl};
    assign rel     = r_off - tstart;

    always_comb begin
        n_sport = r_sport;
        n_dport = r_dport;
        n_thl   = r_thl;
        if (take && ipv4_ok && r_off >= tstart) begin
            if (rel == 16'd0) n_sport = {i_frame_byte, 8'd0};
            if (rel == 16'd1) n_sport = {r_sport[15:8], i_frame_byte};
            if (rel == 16'd2) n_dport = {i_frame_byte, 8'd0};
            if (rel == 16'd3) n_dport = {r_dport[15:8], i_frame_byte};
            if (n_proto == PROTO_TCP && rel == 16'd12) n_thl = {i_frame_byte[7:4], 2'b00};
        end
    end

    // Payload start relative to the transport header.
    always_comb begin
        if (n_proto == PROTO_UDP) ps = 16'd8;
        else if (n_proto == PROTO_TCP && n_thl >= 6'd20) ps = {10'd0, n_thl};
        else ps = 16'd0;
    end

    assign pl_en = take && ipv4_ok && r_off >= tstart && ps != 16'd0 && rel >= ps
                   && !(n_proto == PROTO_TCP && rel <= 16'd12);
    assign ppos    = rel - ps;
    assign http_en = pl_en && (ppos < r_cfg.http_window);

    fpc_http_match u_http (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_en     (http_en),
        .i_pos    (ppos),
        .i_byte   (i_frame_byte),
        .o_status (hs)
    );

    // Head bytes including the current one.
    logic [7:0] h [HEAD_BYTES];
    always_comb begin
        for (int k = 0; k < HEAD_BYTES; k++) begin
            h[k] = r_head[k];
            if (pl_en && ppos == 16'(k)) h[k] = i_frame_byte;
        end
    end

    // Frame classification on the last byte.
    logic [16:0] len, start, plen;
    logic [3:0]  cls;
    logic        anom;
    logic        tcp, http_p, dns_p, tls_p;
    logic [15:0] q, a, ver;
    logic        dns_an, tls_an;
    logic [3:0]  dns_cls, tls_cls, http_cls;
    logic        http_an;

    assign len   = {1'b0, r_off} + 17'd1;
    assign start = 17'(tstart) + {1'b0, ps};
    assign plen  = (n_ether == ETHERTYPE_IPV4 && n_iphl >= 6'd20 && ps != 16'd0
                    && len > start) ? len - start : 17'd0;
    assign tcp    = (n_proto == PROTO_TCP);
    assign http_p = (n_sport == r_cfg.http_port) || (n_dport == r_cfg.http_port);
    assign dns_p  = (n_sport == r_cfg.dns_port) || (n_dport == r_cfg.dns_port);
    assign tls_p  = (n_sport == r_cfg.tls_port) || (n_dport == r_cfg.tls_port);
    assign q   = {h[4], h[5]};
    assign a   = {h[6], h[7]};
    assign ver = {h[1], h[2]};

    always_comb begin
        dns_an = 1'b0;
        dns_cls = CLS_NONE;
        if (plen >= 17'd12) begin
            dns_an  = (q > r_cfg.dns_limit) || (a > r_cfg.dns_limit);
            dns_cls = h[2][7] ? CLS_DNS_RESP : CLS_DNS_QUERY;
        end
        tls_an = 1'b0;
        tls_cls = CLS_NONE;
        if (plen >= 17'd5) begin
            tls_an = ver < r_cfg.tls_minver;
            if (h[0] == 8'd22 && plen >= 17'd6) tls_cls = CLS_TLS_HSHAKE;
            else if (h[0] == 8'd23) tls_cls = CLS_TLS_DATA;
            else tls_cls = CLS_TLS_OTHER;
        end
        http_an = 1'b0;
        if (hs.req) http_cls = CLS_HTTP_REQ;
        else if (hs.resp) http_cls = CLS_HTTP_RESP;
        else if (hs.any) begin
            http_cls = CLS_HTTP_BAD;
            http_an = 1'b1;
        end else http_cls = CLS_NONE;
    end

    always_comb begin
        cls = CLS_NONE;
        anom = 1'b0;
        if (plen != 17'd0) begin
            if (!tcp) begin
                if (dns_p) begin cls = dns_cls; anom = dns_an; end
            end else if (http_p) begin
                cls = http_cls; anom = http_an;
            end else if (dns_p) begin
                cls = dns_cls; anom = dns_an;
            end else if (tls_p) begin
                cls = tls_cls; anom = tls_an;
            end else if (plen >= 17'd4
                         && ((h[0] == 8'h47 && h[1] == 8'h45 && h[2] == 8'h54 && h[3] == 8'h20)
                          || (h[0] == 8'h50 && h[1] == 8'h4f && h[2] == 8'h53
                              && h[3] == 8'h54))) begin
                cls = http_cls; anom = http_an;
            end else if (plen >= 17'd5 && h[0] >= 8'd20 && h[0] <= 8'd23 && h[1] == 8'd3
                         && h[2] >= 8'd1 && h[2] <= 8'd4) begin
                cls = tls_cls; anom = tls_an;
            end
        end
    end

    // Counter selection.
    logic       cnt_hit;
    logic [2:0] cnt_k;
    logic [CW-1:0] cnt_new, anom_new;
    always_comb begin
        cnt_hit = 1'b1;
        cnt_k = 3'd0;
        case (cls)
            CLS_HTTP_REQ:   cnt_k = 3'd0;
            CLS_HTTP_RESP:  cnt_k = 3'd1;
            CLS_DNS_QUERY:  cnt_k = 3'd2;
            CLS_DNS_RESP:   cnt_k = 3'd3;
            CLS_TLS_HSHAKE: cnt_k = 3'd4;
            CLS_TLS_DATA:   cnt_k = 3'd5;
            default:        cnt_hit = 1'b0;
        endcase
    end
    assign cnt_new  = r_cnt[cnt_k] + CW'(1);
    assign anom_new = anom ? r_cnt[6] + CW'(1) : r_cnt[6];

    function automatic logic [31:0] to32(input logic [CW-1:0] v);
        logic [CW+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.http_port   <= 16'd80;
            r_cfg.dns_port    <= 16'd53;
            r_cfg.tls_port    <= 16'd443;
            r_cfg.dns_limit   <= 16'd100;
            r_cfg.tls_minver  <= 16'h0301;
            r_cfg.http_window <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HTTP_PORT:  r_cfg.http_port   <= i_cfg_data;
                REG_DNS_PORT:   r_cfg.dns_port    <= i_cfg_data;
                REG_TLS_PORT:   r_cfg.tls_port    <= i_cfg_data;
                REG_DNS_LIMIT:  r_cfg.dns_limit   <= i_cfg_data;
                REG_TLS_MINVER: r_cfg.tls_minver  <= i_cfg_data;
                REG_HTTP_WIN:   r_cfg.http_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-frame parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_off   <= 16'd0;
            r_ether <= 16'd0;
            r_iphl  <= 6'd0;
            r_proto <= 8'd0;
            r_thl   <= 6'd0;
            r_sport <= 16'd0;
            r_dport <= 16'd0;
        end else if (accept) begin
            if (take) r_off <= r_off + 16'd1;
            r_ether <= n_ether;
            r_iphl  <= n_iphl;
            r_proto <= n_proto;
            r_thl   <= n_thl;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

    // Payload head store.
    always_ff @(posedge i_clk) begin
        if (pl_en && ppos < 16'(HEAD_BYTES))
            r_head[ppos[HIDX-1:0]] <= i_frame_byte;
    end

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) r_cnt[k] <= '0;
        end else if (clear) begin
            if (cnt_hit) r_cnt[cnt_k] <= cnt_new;
            r_cnt[6] <= anom_new;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (clear) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_class <= cls;
            r_anom  <= anom;
            r_ctot  <= cnt_hit ? to32(cnt_new) : 32'd0;
            r_atot  <= to32(anom_new);
        end
    end

    assign o_valid         = r_valid;
    assign o_frame_class   = r_class;
    assign o_anomaly_seen  = r_anom;
    assign o_class_total   = r_ctot;
    assign o_anomaly_total = r_atot;

endmodule

// ===== hdl/fpc_checker.sv =====
// ---------------------------------------------------------------------------
// fpc_checker
// Port-level checks of the frame classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "frame_protocol_classifier_macros.svh"

module fpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_frame_end,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_frame_class,
    input logic        o_anomaly_seen,
    input logic [31:0] o_class_total
);
    import fpc_pkg::*;

    `FPC_ASSERT_NEXT(a_result_follows_end, i_clk, i_rst_n, i_valid && !o_stall && i_frame_end, o_valid, "no result after frame end")
    `FPC_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while output free")
    `FPC_ASSERT_IMPL(a_no_class_no_total, i_clk, i_rst_n, o_valid && (o_frame_class == CLS_NONE || o_frame_class == CLS_HTTP_BAD || o_frame_class == CLS_TLS_OTHER), o_class_total == 32'd0, "class without counter has total")
    `FPC_ASSERT_IMPL(a_malformed_anomaly, i_clk, i_rst_n, o_valid && o_frame_class == CLS_HTTP_BAD, o_anomaly_seen, "malformed HTTP without anomaly")

endmodule

bind frame_protocol_classifier fpc_checker u_fpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_frame_end    (i_frame_end),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frame_class  (o_frame_class),
    .o_anomaly_seen (o_anomaly_seen),
    .o_class_total  (o_class_total)
);
